[rtl/ihp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihp_pkg
// Shared types and constants of the indexed min-heap.
// ----------------------------------------------------------------------------
package ihp_pkg;

	localparam int CAPACITY    = 1024;
	localparam int KEY_BITS    = 64;
	localparam int HANDLE_BITS = 16;
	localparam int POS_W       = 10;
	localparam int CNT_W       = 11;
	localparam int IDX_W       = POS_W + 2;

	localparam logic [2:0] REQ_APPEND  = 3'd0;
	localparam logic [2:0] REQ_REMOVE  = 3'd1;
	localparam logic [2:0] REQ_WRITE   = 3'd2;
	localparam logic [2:0] REQ_REPLACE = 3'd3;
	localparam logic [2:0] REQ_READ    = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [2:0]             req_type;
		logic [POS_W-1:0]       position;
		logic [KEY_BITS-1:0]    key;
		logic [HANDLE_BITS-1:0] handle;
	} req_t;

	typedef struct packed {
		logic [1:0]             status;
		logic [KEY_BITS-1:0]    out_key;
		logic [HANDLE_BITS-1:0] out_handle;
		logic [POS_W-1:0]       new_position;
		logic [CNT_W-1:0]       entry_count;
		logic                   last;
	} rsp_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]    key;
		logic [HANDLE_BITS-1:0] handle;
	} entry_t;

	localparam int ENTRY_W = KEY_BITS + HANDLE_BITS;

endpackage

[rtl/ihp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ihp_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [$clog2(D)-1:0] wr_addr,
	input  logic [W-1:0]         wr_data,
	input  logic                 rd_en,
	input  logic [$clog2(D)-1:0] rd_addr,
	output logic [W-1:0]         rd_data
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/indexed_min_heap_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_top
// Binary min-heap of (key, handle) entries in one RAM, reporting every move.
// ----------------------------------------------------------------------------
// append and error requests are answered from idle; read/remove/key write read
//   the RAM first (S_RD_ONE); re-place loads the entry (S_RP_LOAD), moves up a
//   level per S_UP_WAIT or down a level via S_DN_L/S_DN_R, then places it (S_FIN)
// one transaction at a time; the single RAM read port sets the pace
// result strobe lasts one cycle, the receiver cannot stall
// reset clears the fill count and control state, the RAM keeps its contents
module indexed_min_heap_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ihp_pkg::req_t req,
	output logic          valid,
	output ihp_pkg::rsp_t rsp
);
	import ihp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_RD_ONE, S_RP_LOAD, S_UP_WAIT, S_DN_L, S_DN_R, S_FIN
	} state_t;

	state_t           state_q;
	req_t             req_q;
	logic [CNT_W-1:0] fill_q;
	logic [POS_W-1:0] p_q;
	entry_t           tk_q;
	entry_t           lent_q;
	logic             first_q;
	rsp_t             rsp_q;
	logic             valid_q;

	// ram port signals
	logic             rd_en, wr_en;
	logic [POS_W-1:0] rd_addr, wr_addr;
	entry_t           wr_data, rdata;
	logic [ENTRY_W-1:0] rdata_raw;

	ihp_ram #(.W(ENTRY_W), .D(CAPACITY)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rdata_raw)
	);
	assign rdata = entry_t'(rdata_raw);

	function automatic logic [IDX_W-1:0] left_of(input logic [POS_W-1:0] p);
		return ({2'b00, p} << 1) + IDX_W'(1);
	endfunction

	function automatic rsp_t mk_rsp(input logic [1:0] st, input entry_t e,
			input logic [POS_W-1:0] pos, input logic [CNT_W-1:0] cnt,
			input logic fin);
		rsp_t r;
		r.status       = st;
		r.out_key      = e.key;
		r.out_handle   = e.handle;
		r.new_position = pos;
		r.entry_count  = cnt;
		r.last         = fin;
		return r;
	endfunction

	// tree neighbors of the current slot
	logic [IDX_W-1:0] fill_x, l_p, r_p, l_d;
	logic [POS_W-1:0] par;
	logic             l_ok_p, r_ok_p, l_ok_d, par_nz, up_move;
	logic             dn_move;
	entry_t           dn_ent;
	logic [POS_W-1:0] dn_idx;
	logic             l_better, r_better;
	logic [KEY_BITS-1:0] bk;

	always_comb begin
		fill_x   = {1'b0, fill_q};
		l_p      = left_of(p_q);
		r_p      = l_p + IDX_W'(1);
		l_ok_p   = l_p < fill_x;
		r_ok_p   = r_p < fill_x;
		par      = (p_q - POS_W'(1)) >> 1;
		par_nz   = par != '0;
		up_move  = rdata.key > tk_q.key;
		// child choice: left wins ties, right only if strictly smaller
		l_better = 1'b0;
		r_better = 1'b0;
		bk       = tk_q.key;
		dn_move  = 1'b0;
		dn_ent   = lent_q;
		dn_idx   = l_p[POS_W-1:0];
		if (state_q == S_DN_L) begin
			dn_move = rdata.key < tk_q.key;
			dn_ent  = rdata;
		end else begin
			l_better = lent_q.key < tk_q.key;
			bk       = l_better ? lent_q.key : tk_q.key;
			r_better = rdata.key < bk;
			dn_move  = l_better || r_better;
			if (r_better) begin
				dn_ent = rdata;
				dn_idx = r_p[POS_W-1:0];
			end
		end
		l_d    = left_of(dn_idx);
		l_ok_d = l_d < fill_x;
	end

	// ram access per state
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req.req_type == REQ_APPEND) begin
						wr_en   = fill_q < CNT_W'(CAPACITY);
						wr_addr = fill_q[POS_W-1:0];
						wr_data = {req.key, req.handle};
					end else if (req.req_type == REQ_REMOVE) begin
						rd_en   = fill_q != '0;
						rd_addr = POS_W'(fill_q - CNT_W'(1));
					end else begin
						rd_en   = fill_q != '0 && {1'b0, req.position} < fill_q;
						rd_addr = req.position;
					end
				end
			end
			S_RD_ONE: begin
				wr_en   = req_q.req_type == REQ_WRITE;
				wr_addr = req_q.position;
				wr_data = {req_q.key, rdata.handle};
			end
			S_RP_LOAD: begin
				if (p_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = par;
				end else begin
					rd_en   = l_ok_p;
					rd_addr = l_p[POS_W-1:0];
				end
			end
			S_UP_WAIT: begin
				if (up_move) begin
					wr_en   = 1'b1;
					wr_addr = p_q;
					wr_data = rdata;
					rd_en   = par_nz;
					rd_addr = (par - POS_W'(1)) >> 1;
				end else begin
					rd_en   = first_q && l_ok_p;
					rd_addr = l_p[POS_W-1:0];
				end
			end
			S_DN_L, S_DN_R: begin
				if (state_q == S_DN_L && r_ok_p) begin
					rd_en   = 1'b1;
					rd_addr = r_p[POS_W-1:0];
				end else if (dn_move) begin
					wr_en   = 1'b1;
					wr_addr = p_q;
					wr_data = dn_ent;
					rd_en   = l_ok_d;
					rd_addr = l_d[POS_W-1:0];
				end
			end
			S_FIN: begin
				wr_en   = 1'b1;
				wr_addr = p_q;
				wr_data = tk_q;
			end
			default: ;
		endcase
	end

	// sequencer and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			valid_q <= 1'b0;
			first_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						p_q   <= req.position;
						if (req.req_type == REQ_APPEND) begin
							valid_q <= 1'b1;
							if (fill_q >= CNT_W'(CAPACITY)) begin
								rsp_q <= mk_rsp(ST_FULL, '0, '0, fill_q, 1'b1);
							end else begin
								fill_q <= fill_q + CNT_W'(1);
								rsp_q  <= mk_rsp(ST_OK, {req.key, req.handle},
									fill_q[POS_W-1:0], fill_q + CNT_W'(1), 1'b1);
							end
						end else if (req.req_type > REQ_READ) begin
							valid_q <= 1'b1;
							rsp_q   <= mk_rsp(ST_OK, '0, '0, fill_q, 1'b1);
						end else if (fill_q == '0) begin
							valid_q <= 1'b1;
							rsp_q   <= mk_rsp(ST_EMPTY, '0, '0, fill_q, 1'b1);
						end else if (req.req_type == REQ_REMOVE) begin
							fill_q  <= fill_q - CNT_W'(1);
							state_q <= S_RD_ONE;
						end else if ({1'b0, req.position} >= fill_q) begin
							valid_q <= 1'b1;
							rsp_q   <= mk_rsp(ST_RANGE, '0, '0, fill_q, 1'b1);
						end else if (req.req_type == REQ_REPLACE) begin
							state_q <= S_RP_LOAD;
						end else begin
							state_q <= S_RD_ONE;
						end
					end
				end
				S_RD_ONE: begin
					valid_q <= 1'b1;
					state_q <= S_IDLE;
					if (req_q.req_type == REQ_REMOVE) begin
						rsp_q <= mk_rsp(ST_OK, rdata, '0, fill_q, 1'b1);
					end else if (req_q.req_type == REQ_WRITE) begin
						rsp_q <= mk_rsp(ST_OK, {req_q.key, rdata.handle},
							req_q.position, fill_q, 1'b1);
					end else begin
						rsp_q <= mk_rsp(ST_OK, rdata, req_q.position, fill_q, 1'b1);
					end
				end
				S_RP_LOAD: begin
					tk_q    <= rdata;
					first_q <= 1'b1;
					if (p_q != '0) begin
						state_q <= S_UP_WAIT;
					end else if (l_ok_p) begin
						state_q <= S_DN_L;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_UP_WAIT: begin
					first_q <= 1'b0;
					if (up_move) begin
						valid_q <= 1'b1;
						rsp_q   <= mk_rsp(ST_OK, rdata, p_q, fill_q, 1'b0);
						p_q     <= par;
						state_q <= par_nz ? S_UP_WAIT : S_FIN;
					end else if (first_q && l_ok_p) begin
						state_q <= S_DN_L;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DN_L, S_DN_R: begin
					if (state_q == S_DN_L && r_ok_p) begin
						lent_q  <= rdata;
						state_q <= S_DN_R;
					end else if (dn_move) begin
						valid_q <= 1'b1;
						rsp_q   <= mk_rsp(ST_OK, dn_ent, p_q, fill_q, 1'b0);
						p_q     <= dn_idx;
						state_q <= l_ok_d ? S_DN_L : S_FIN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					valid_q <= 1'b1;
					rsp_q   <= mk_rsp(ST_OK, tk_q, p_q, fill_q, 1'b1);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy  = state_q != S_IDLE;
	assign valid = valid_q;
	assign rsp   = rsp_q;

	// a move report is never the end of a transaction
	a_move_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !rsp.last |-> busy) else $error("move report outside a re-place");

	// fill count never passes capacity
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY)) else $error("fill count above capacity");

	// error statuses always close the transaction
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && rsp.status != ST_OK |-> rsp.last) else $error("error not final");

	// an accepted transaction either keeps the block busy or reports at once
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || valid) else $error("transaction dropped");

endmodule

[bench/indexed_min_heap_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_top_tb
// Self-checking bench for the indexed min-heap. A behavioral heap model
// tracks every accepted request and queues the responses it should produce.
// Directed tests cover empty and range errors, the unused request codes and
// field extremes, then random appends, write/re-place pairs and other requests on a live heap.
// Start idles in random bursts and responses are checked on the fly.
// ----------------------------------------------------------------------------
module indexed_min_heap_top_tb;
	import ihp_pkg::*;

	// request codes with no defined operation
	localparam logic [2:0] REQ_SPARE_5 = 3'd5;
	localparam logic [2:0] REQ_SPARE_6 = 3'd6;
	localparam logic [2:0] REQ_SPARE_7 = 3'd7;
	localparam int RANDOM_ITEMS = 215;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	req_t  req;
	logic  valid;
	rsp_t  rsp;

	indexed_min_heap_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .valid(valid), .rsp(rsp)
	);

	// shadow heap held by the bench
	logic [KEY_BITS-1:0]    shadow_key [CAPACITY];
	logic [HANDLE_BITS-1:0] shadow_hdl [CAPACITY];
	int unsigned            shadow_fill;

	rsp_t pending_rsp [$];
	int   mismatches;
	int   sent_count;
	int   rsp_count;
	int   move_count;
	int   burst_left;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// generous ceiling on the whole run
	initial begin
		#4ms;
		$display("timeout with %0d responses outstanding", pending_rsp.size());
		$display("indexed_min_heap_top: mismatch");
		$finish;
	end

	// queue one expected response
	function automatic void expect_rsp(logic [1:0] st, logic [KEY_BITS-1:0] k,
			logic [HANDLE_BITS-1:0] h, int unsigned slot, logic fin);
		rsp_t r;
		r.status       = st;
		r.out_key      = k;
		r.out_handle   = h;
		r.new_position = slot[POS_W-1:0];
		r.entry_count  = shadow_fill[CNT_W-1:0];
		r.last         = fin;
		pending_rsp = {pending_rsp, r};
	endfunction

	// re-place: sift up when the parent is greater, otherwise sift down
	function automatic void heap_replace(int unsigned p);
		logic [KEY_BITS-1:0]    hold_k;
		logic [HANDLE_BITS-1:0] hold_h;
		logic [KEY_BITS-1:0]    best_k;
		int unsigned            par;
		int unsigned            best;
		bit                     moving;
		hold_k = shadow_key[p];
		hold_h = shadow_hdl[p];
		if (p > 0 && shadow_key[(p + 1) / 2 - 1] > hold_k) begin
			moving = 1'b1;
			while (moving && p > 0) begin
				par = (p + 1) / 2 - 1;
				if (shadow_key[par] > hold_k) begin
					shadow_key[p] = shadow_key[par];
					shadow_hdl[p] = shadow_hdl[par];
					expect_rsp(ST_OK, shadow_key[p], shadow_hdl[p], p, 1'b0);
					move_count++;
					p = par;
				end else begin
					moving = 1'b0;
				end
			end
		end else begin
			moving = 1'b1;
			while (moving) begin
				best   = p;
				best_k = hold_k;
				// left child wins ties
				if (2 * p + 1 < shadow_fill && shadow_key[2 * p + 1] < best_k) begin
					best   = 2 * p + 1;
					best_k = shadow_key[best];
				end
				if (2 * p + 2 < shadow_fill && shadow_key[2 * p + 2] < best_k)
					best = 2 * p + 2;
				if (best == p) begin
					moving = 1'b0;
				end else begin
					shadow_key[p] = shadow_key[best];
					shadow_hdl[p] = shadow_hdl[best];
					expect_rsp(ST_OK, shadow_key[p], shadow_hdl[p], p, 1'b0);
					move_count++;
					p = best;
				end
			end
		end
		shadow_key[p] = hold_k;
		shadow_hdl[p] = hold_h;
		expect_rsp(ST_OK, hold_k, hold_h, p, 1'b1);
	endfunction

	// expected responses for one accepted transaction
	function automatic void heap_predict(req_t r);
		int unsigned p;
		p = r.position;
		if (r.req_type == REQ_APPEND) begin
			if (shadow_fill >= CAPACITY) begin
				expect_rsp(ST_FULL, '0, '0, 0, 1'b1);
			end else begin
				shadow_key[shadow_fill] = r.key;
				shadow_hdl[shadow_fill] = r.handle;
				shadow_fill++;
				expect_rsp(ST_OK, r.key, r.handle, shadow_fill - 1, 1'b1);
			end
		end else if (r.req_type > REQ_READ) begin
			expect_rsp(ST_OK, '0, '0, 0, 1'b1);
		end else if (shadow_fill == 0) begin
			expect_rsp(ST_EMPTY, '0, '0, 0, 1'b1);
		end else if (r.req_type == REQ_REMOVE) begin
			shadow_fill--;
			expect_rsp(ST_OK, shadow_key[shadow_fill], shadow_hdl[shadow_fill], 0, 1'b1);
		end else if (p >= shadow_fill) begin
			expect_rsp(ST_RANGE, '0, '0, 0, 1'b1);
		end else if (r.req_type == REQ_WRITE) begin
			shadow_key[p] = r.key;
			expect_rsp(ST_OK, r.key, shadow_hdl[p], p, 1'b1);
		end else if (r.req_type == REQ_REPLACE) begin
			heap_replace(p);
		end else begin
			expect_rsp(ST_OK, shadow_key[p], shadow_hdl[p], p, 1'b1);
		end
	endfunction

	// drive one transaction, honoring the burst/gap pattern of the sender
	task automatic send_req(logic [2:0] op, int unsigned pos,
			logic [KEY_BITS-1:0] k, logic [HANDLE_BITS-1:0] h);
		req_t r;
		int   gap;
		if (burst_left == 0) begin
			// mostly short gaps, some back-to-back bursts with none
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		r.req_type = op;
		r.position = pos[POS_W-1:0];
		r.key      = k;
		r.handle   = h;
		@(negedge clk);
		start <= 1'b1;
		req   <= r;
		// accepted at the first rising edge with busy low
		do @(posedge clk); while (busy);
		heap_predict(r);
		sent_count++;
	endtask

	// drop start before waiting, so the last transaction is not taken again
	task automatic drain_responses();
		@(negedge clk);
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	function automatic logic [KEY_BITS-1:0] rand_key();
		return {$urandom(), $urandom()};
	endfunction

	// response checker: every strobe must match the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && valid) begin
			rsp_count++;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response %p", rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status || rsp.out_key !== want.out_key ||
						rsp.out_handle !== want.out_handle ||
						rsp.new_position !== want.new_position ||
						rsp.entry_count !== want.entry_count ||
						rsp.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"response %0d: expected st=%0d key=%h hdl=%h ",
							"pos=%0d cnt=%0d last=%0d, got st=%0d key=%h hdl=%h ",
							"pos=%0d cnt=%0d last=%0d"},
							rsp_count, want.status, want.out_key, want.out_handle,
							want.new_position, want.entry_count, want.last,
							rsp.status, rsp.out_key, rsp.out_handle,
							rsp.new_position, rsp.entry_count, rsp.last);
				end
			end
		end
	end

	// empty heap errors and the unused request codes
	task automatic test_empty_heap();
		send_req(REQ_REMOVE, 0, '0, '0);
		send_req(REQ_WRITE, 0, '1, '1);
		send_req(REQ_REPLACE, 1023, '0, '0);
		send_req(REQ_READ, 0, '0, '0);
		send_req(REQ_SPARE_5, 1023, '1, '1);
		send_req(REQ_SPARE_6, 0, '0, '0);
		send_req(REQ_SPARE_7, 512, rand_key(), 16'h5a5a);
	endtask

	// key and handle extremes, range errors, re-place moving down and staying put
	task automatic test_small_heap();
		send_req(REQ_APPEND, 1023, '1, '1);
		send_req(REQ_APPEND, 0, 64'h0, 16'h0);
		send_req(REQ_APPEND, 0, 64'h8000_0000_0000_0000, 16'h8000);
		send_req(REQ_APPEND, 0, 64'h1, 16'h0001);
		send_req(REQ_READ, 3, '0, '0);
		send_req(REQ_READ, 4, '0, '0);           // one past the end
		send_req(REQ_WRITE, 1023, '0, '0);       // far out of range
		send_req(REQ_REPLACE, 3, '0, '0);        // parent is smaller, stays in place
		send_req(REQ_WRITE, 0, '1, '1);          // root becomes the largest key
		send_req(REQ_REPLACE, 0, '0, '0);        // moves down
		send_req(REQ_APPEND, 0, 64'h1, 16'h0002);
		send_req(REQ_WRITE, 1, 64'h1, '0);       // left child of the root keeps key 1
		send_req(REQ_WRITE, 0, 64'h2, '0);
		send_req(REQ_REPLACE, 0, '0, '0);        // moves down to the left child, then the right
		send_req(REQ_REPLACE, 2, '0, '0);
		while (shadow_fill > 0) send_req(REQ_REMOVE, 0, '0, '0);
		send_req(REQ_REMOVE, 0, '0, '0);
		drain_responses();
	endtask

	// random traffic: appends, write then re-place pairs on a live heap, plus noise
	task automatic test_random_traffic();
		int          n;
		int          pick;
		int unsigned p;
		logic [2:0]  op;
		n = 0;
		while (n < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			p = (shadow_fill > 0 && $urandom_range(0, 7) != 0) ?
				$urandom_range(0, shadow_fill - 1) : $urandom_range(0, 1023);
			if (pick < 30 || shadow_fill < 4) begin
				send_req(REQ_APPEND, $urandom(), rand_key(), $urandom());
				n++;
			end else if (pick < 65) begin
				send_req(REQ_WRITE, p, rand_key(), $urandom());
				send_req(REQ_REPLACE, p, rand_key(), $urandom());
				n += 2;
			end else begin
				case (pick % 6)
					0: op = REQ_REMOVE;
					1: op = REQ_READ;
					2: op = REQ_REPLACE;
					3: op = REQ_WRITE;
					4: op = (shadow_fill > 200) ? REQ_REMOVE : REQ_READ;
					default: op = 3'($urandom_range(5, 7));
				endcase
				send_req(op, p, rand_key(), $urandom());
				n++;
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		req         = '0;
		shadow_fill = 0;
		mismatches  = 0;
		sent_count  = 0;
		rsp_count   = 0;
		move_count  = 0;
		burst_left  = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_heap();
		test_small_heap();
		test_random_traffic();

		@(negedge clk);
		start <= 1'b0;
		drain_responses();
		repeat (40) @(posedge clk);

		$display("sent %0d transactions, checked %0d responses, %0d sift moves",
			sent_count, rsp_count, move_count);
		$display("covered empty/range errors, spare codes and random sifts on a live heap");
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("indexed_min_heap_top: match");
		end else begin
			$display("%0d mismatches, %0d responses missing", mismatches,
				pending_rsp.size());
			$display("indexed_min_heap_top: mismatch");
		end
		$finish;
	end

endmodule
